// ===== rtl/core/mspid_pkg.sv =====
// ----------------------------------------------------------------------------
// mspid_pkg
// Shared types and constants for the motor speed velocity-form PID block.
// ----------------------------------------------------------------------------
`default_nettype none

package mspid_pkg;

  // field widths
  localparam int COUNT_W = 13;
  localparam int RATE_W  = 10;
  localparam int GAIN_W  = 16;
  localparam int SPEED_W = 24;
  localparam int ERR_W   = 25;
  localparam int DUTY_W  = 8;
  localparam int FRAC_W  = 8;

  // shared multiplier: narrow operand takes gains and the count,
  // wide operand takes error differences and the sample rate
  localparam int MUL_A_W = 16;
  localparam int MUL_B_W = 27;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 48;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 24;

  typedef enum logic [CFG_AW-1:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_I      = 3'd1,
    REG_GAIN_D      = 3'd2,
    REG_TARGET      = 3'd3,
    REG_SAMPLE_RATE = 3'd4
  } reg_idx_t;

  localparam logic [RATE_W-1:0] RATE_RESET = 10'd100;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPEED,
    ST_ERR,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_ACC,
    ST_CLAMP,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/motor_speed_velocity_pid.sv =====
// ----------------------------------------------------------------------------
// motor_speed_velocity_pid
// Velocity-form PID speed loop: one encoder word in, one duty/speed word out.
// ----------------------------------------------------------------------------
// One input word per sample tick; the block answers with one result word.
// All products go through a single 16 x 27 signed multiplier stepped by a
// small sequencer: speed, then the P, I and D terms, each registered and
// summed in the next cycle, then a clamp to +/-DUTY_MAX in Q.8. With a
// nonzero setpoint an item steps through speed, error, P, I, D,
// accumulate, clamp and done; with a zero setpoint it goes from error
// straight to done. The input is stalled while an item is in work, and
// a finished result waits in the output register; a result still
// waiting there holds the sequencer in its last step.
`default_nettype none

module motor_speed_velocity_pid #(
  parameter int DUTY_MAX = 255
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [mspid_pkg::CFG_AW-1:0]         cfg_addr,
  input  wire logic [mspid_pkg::CFG_DW-1:0]         cfg_wdata,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [mspid_pkg::COUNT_W-1:0] in_encoder_count,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [mspid_pkg::DUTY_W-1:0]              out_fwd_duty,
  output logic [mspid_pkg::DUTY_W-1:0]              out_rev_duty,
  output logic signed [mspid_pkg::SPEED_W-1:0]      out_measured_speed
);

  import mspid_pkg::*;

  localparam longint LIMIT = longint'(DUTY_MAX) * (longint'(1) << FRAC_W);
  localparam int     DRV_W = $clog2(LIMIT + 1) + 1;
  localparam logic signed [ACC_W-1:0] LIMIT_POS = ACC_W'(LIMIT);
  localparam logic signed [ACC_W-1:0] LIMIT_NEG = -ACC_W'(LIMIT);

  // configuration
  logic signed [GAIN_W-1:0]  gain_p_r, gain_i_r, gain_d_r;
  logic signed [SPEED_W-1:0] target_r;
  logic [RATE_W-1:0]         rate_r;

  // loop state
  logic signed [DRV_W-1:0] last_drive_r, last_drive_nxt;
  logic signed [ERR_W-1:0] last_err_r, last_err_nxt;
  logic signed [ERR_W-1:0] older_err_r, older_err_nxt;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // datapath
  logic signed [COUNT_W-1:0] count_r, count_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [ERR_W-1:0]   err_r, err_nxt;
  logic signed [SPEED_W-1:0] speed_r, speed_nxt;
  logic [DUTY_W-1:0]         fwd_r, fwd_nxt, rev_r, rev_nxt;
  logic [DUTY_W-1:0]         out_fwd_r, out_fwd_nxt, out_rev_r, out_rev_nxt;
  logic signed [SPEED_W-1:0] out_speed_r, out_speed_nxt;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [ACC_W-1:0]   drive_clamped;
  logic signed [ACC_W-1:0]   drive_mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= '0;
      gain_i_r <= '0;
      gain_d_r <= '0;
      target_r <= '0;
      rate_r   <= RATE_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_GAIN_P:      gain_p_r <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I:      gain_i_r <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:      gain_d_r <= cfg_wdata[GAIN_W-1:0];
        REG_TARGET:      target_r <= cfg_wdata[SPEED_W-1:0];
        REG_SAMPLE_RATE: rate_r   <= cfg_wdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SPEED: begin
        mul_a = MUL_A_W'(count_r);
        mul_b = $signed(MUL_B_W'(rate_r));
      end
      ST_MUL_P: begin
        mul_a = gain_p_r;
        mul_b = MUL_B_W'(err_r) - MUL_B_W'(last_err_r);
      end
      ST_MUL_I: begin
        mul_a = gain_i_r;
        mul_b = MUL_B_W'(err_r);
      end
      ST_MUL_D: begin
        mul_a = gain_d_r;
        mul_b = MUL_B_W'(err_r) - (MUL_B_W'(last_err_r) <<< 1) + MUL_B_W'(older_err_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    if (acc_r > LIMIT_POS) begin
      drive_clamped = LIMIT_POS;
    end else if (acc_r < LIMIT_NEG) begin
      drive_clamped = LIMIT_NEG;
    end else begin
      drive_clamped = acc_r;
    end
    drive_mag = drive_clamped[ACC_W-1] ? -drive_clamped : drive_clamped;
  end

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    last_drive_nxt = last_drive_r;
    last_err_nxt   = last_err_r;
    older_err_nxt  = older_err_r;
    count_nxt      = count_r;
    prod_nxt       = prod_r;
    acc_nxt        = acc_r;
    err_nxt        = err_r;
    speed_nxt      = speed_r;
    fwd_nxt        = fwd_r;
    rev_nxt        = rev_r;
    out_fwd_nxt    = out_fwd_r;
    out_rev_nxt    = out_rev_r;
    out_speed_nxt  = out_speed_r;
    in_stall       = (state_r != ST_IDLE);

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          count_nxt = in_encoder_count;
          state_nxt = ST_SPEED;
        end
      end
      ST_SPEED: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = ST_ERR;
      end
      ST_ERR: begin
        // |count * rate| stays below 2^23, so the speed never saturates
        speed_nxt = prod_r[SPEED_W-1:0];
        if (target_r == '0) begin
          last_err_nxt  = '0;
          older_err_nxt = '0;
          fwd_nxt       = '0;
          rev_nxt       = '0;
          state_nxt     = ST_DONE;
        end else begin
          err_nxt   = ERR_W'(target_r) - ERR_W'($signed(prod_r[SPEED_W-1:0]));
          acc_nxt   = ACC_W'(last_drive_r);
          state_nxt = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = ST_MUL_I;
      end
      ST_MUL_I: begin
        acc_nxt   = acc_r + ACC_W'(prod_r);
        prod_nxt  = mul_a * mul_b;
        state_nxt = ST_MUL_D;
      end
      ST_MUL_D: begin
        acc_nxt   = acc_r + ACC_W'(prod_r);
        prod_nxt  = mul_a * mul_b;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        acc_nxt   = acc_r + ACC_W'(prod_r);
        state_nxt = ST_CLAMP;
      end
      ST_CLAMP: begin
        last_drive_nxt = DRV_W'(drive_clamped);
        older_err_nxt  = last_err_r;
        last_err_nxt   = err_r;
        // duty is the magnitude with the fraction dropped
        if (drive_clamped > 0) begin
          fwd_nxt = DUTY_W'(drive_mag >>> FRAC_W);
          rev_nxt = '0;
        end else begin
          fwd_nxt = '0;
          rev_nxt = DUTY_W'(drive_mag >>> FRAC_W);
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_fwd_nxt   = fwd_r;
          out_rev_nxt   = rev_r;
          out_speed_nxt = speed_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      last_drive_r <= '0;
      last_err_r   <= '0;
      older_err_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      last_drive_r <= last_drive_nxt;
      last_err_r   <= last_err_nxt;
      older_err_r  <= older_err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    count_r     <= count_nxt;
    prod_r      <= prod_nxt;
    acc_r       <= acc_nxt;
    err_r       <= err_nxt;
    speed_r     <= speed_nxt;
    fwd_r       <= fwd_nxt;
    rev_r       <= rev_nxt;
    out_fwd_r   <= out_fwd_nxt;
    out_rev_r   <= out_rev_nxt;
    out_speed_r <= out_speed_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_fwd_duty       = out_fwd_r;
  assign out_rev_duty       = out_rev_r;
  assign out_measured_speed = out_speed_r;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the velocity-form PID motor speed loop.
// Encoder words go in through a queue-fed driver and results are checked by a
// monitor against an in-bench PID predictor. The gains, setpoint and sample
// rate change between phases while the block is idle. Both sides idle at
// random, and the result side holds off for long stretches so that the input
// backs up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import mspid_pkg::*;

  localparam int DUTY_MAX     = 255;
  localparam int IDLE_PCT     = 19;
  localparam int RANDOM_ITEMS = 1700;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int CALM_LO      = 600;
  localparam int CALM_HI      = 900;

  // indexes with no register behind them
  localparam logic [CFG_AW-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_AW-1:0] REG_SPARE_HI = 3'd7;

  localparam longint SPEED_TOP = (64'sd1 <<< (SPEED_W - 1)) - 1;
  localparam longint SPEED_BOT = -(64'sd1 <<< (SPEED_W - 1));
  localparam longint COUNT_TOP = (64'sd1 <<< (COUNT_W - 1)) - 1;
  localparam longint COUNT_BOT = -(64'sd1 <<< (COUNT_W - 1));

  typedef struct packed {
    logic [DUTY_W-1:0]         fwd;
    logic [DUTY_W-1:0]         rev;
    logic signed [SPEED_W-1:0] speed;
  } duty_word_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [CFG_AW-1:0]         cfg_addr = '0;
  logic [CFG_DW-1:0]         cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [COUNT_W-1:0] in_encoder_count = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [DUTY_W-1:0]         out_fwd_duty;
  logic [DUTY_W-1:0]         out_rev_duty;
  logic signed [SPEED_W-1:0] out_measured_speed;

  // shadow of the configuration and of the loop state
  logic signed [GAIN_W-1:0]  m_kp = '0;
  logic signed [GAIN_W-1:0]  m_ki = '0;
  logic signed [GAIN_W-1:0]  m_kd = '0;
  logic signed [SPEED_W-1:0] m_target = '0;
  logic [RATE_W-1:0]         m_rate = RATE_RESET;
  longint                    m_drive = 0;
  longint                    m_err1 = 0;
  longint                    m_err2 = 0;

  logic signed [COUNT_W-1:0] ticks_todo[$];
  duty_word_t                duty_due[$];
  int                        ticks_sent = 0;
  int                        words_seen = 0;
  int                        errors = 0;
  int                        hold_left = 0;
  int                        next_hold_at = 350;
  int                        cycle_cnt = 0;

  motor_speed_velocity_pid #(
    .DUTY_MAX(DUTY_MAX)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_encoder_count   (in_encoder_count),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_fwd_duty       (out_fwd_duty),
    .out_rev_duty       (out_rev_duty),
    .out_measured_speed (out_measured_speed)
  );

  always #6 clk = ~clk;

  task automatic log_error(input string msg);
    $display("error: %s", msg);
    errors++;
  endtask

  // one PID step on the shadow state, as the block should take it
  function automatic duty_word_t pid_step(input logic signed [COUNT_W-1:0] count);
    duty_word_t w;
    longint     spd;
    longint     err;
    longint     drv;
    longint     lim;
    w = '0;
    lim = longint'(DUTY_MAX) * 256;
    spd = longint'(count) * longint'({1'b0, m_rate});
    if (spd > SPEED_TOP) spd = SPEED_TOP;
    if (spd < SPEED_BOT) spd = SPEED_BOT;
    w.speed = spd[SPEED_W-1:0];
    if (m_target == 0) begin
      // stopped: errors cleared, drive kept
      m_err1 = 0;
      m_err2 = 0;
    end else begin
      err = longint'(m_target) - spd;
      drv = m_drive + longint'(m_kp) * (err - m_err1) + longint'(m_ki) * err
          + longint'(m_kd) * (err - 2 * m_err1 + m_err2);
      if (drv > lim) drv = lim;
      if (drv < -lim) drv = -lim;
      if (drv > 0) w.fwd = DUTY_W'(drv >>> FRAC_W);
      else if (drv < 0) w.rev = DUTY_W'((-drv) >>> FRAC_W);
      m_drive = drv;
      m_err2 = m_err1;
      m_err1 = err;
    end
    return w;
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    if ($urandom_range(0, 4) == 0) return GAIN_W'($urandom);
    return GAIN_W'(int'($urandom_range(0, 256)) - 128);
  endfunction

  function automatic logic [SPEED_W-1:0] rand_target();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return SPEED_W'($urandom);
      default: return SPEED_W'(int'($urandom_range(0, 600000)) - 300000);
    endcase
  endfunction

  function automatic logic [RATE_W-1:0] rand_rate();
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? '0 : '1;
    return RATE_W'($urandom_range(1, 1000));
  endfunction

  // counts mostly near the setpoint so the loop settles instead of pinning
  function automatic logic signed [COUNT_W-1:0] rand_count();
    longint base;
    if (m_rate == 0 || $urandom_range(0, 4) == 0) return COUNT_W'($urandom_range(0, 8191));
    base = longint'(m_target) / longint'({1'b0, m_rate});
    if (base > COUNT_TOP) base = COUNT_TOP;
    if (base < COUNT_BOT) base = COUNT_BOT;
    base = base + longint'($urandom_range(0, 16)) - 8;
    if (base > COUNT_TOP) base = COUNT_TOP;
    if (base < COUNT_BOT) base = COUNT_BOT;
    return base[COUNT_W-1:0];
  endfunction

  task automatic put_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_GAIN_P:      m_kp = val[GAIN_W-1:0];
      REG_GAIN_I:      m_ki = val[GAIN_W-1:0];
      REG_GAIN_D:      m_kd = val[GAIN_W-1:0];
      REG_TARGET:      m_target = val[SPEED_W-1:0];
      REG_SAMPLE_RATE: m_rate = val[RATE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                               input logic [GAIN_W-1:0] kd, input logic [SPEED_W-1:0] tgt,
                               input logic [RATE_W-1:0] rate);
    // a write to an unmapped index must leave everything alone
    put_reg(CFG_AW'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), CFG_DW'($urandom));
    put_reg(REG_GAIN_P, CFG_DW'(kp));
    put_reg(REG_GAIN_I, CFG_DW'(ki));
    put_reg(REG_GAIN_D, CFG_DW'(kd));
    put_reg(REG_TARGET, CFG_DW'(tgt));
    put_reg(REG_SAMPLE_RATE, CFG_DW'(rate));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // looked at mid-cycle so the driver and monitor updates have settled
  task automatic drain();
    while (ticks_todo.size() != 0 || in_valid || duty_due.size() != 0) @(negedge clk);
  endtask

  // stimulus
  initial begin
    int planned;
    int n;
    planned = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: setpoint zero, default rate
    ticks_todo.push_back(-13'sd4096);
    ticks_todo.push_back(13'sd4095);
    ticks_todo.push_back(13'sd0);
    drain();

    // nonzero setpoint, zero gains: drive stays exactly zero
    apply_setting(16'h0000, 16'h0000, 16'h0000, 24'd100, 10'd100);
    ticks_todo.push_back(13'sd1);
    ticks_todo.push_back(-13'sd1);
    drain();

    // unity-ish gains, both clamps
    apply_setting(16'h0100, 16'h0010, 16'h0008, 24'd5000, 10'd1000);
    ticks_todo.push_back(13'sd0);
    ticks_todo.push_back(13'sd5);
    ticks_todo.push_back(13'sd4095);
    ticks_todo.push_back(-13'sd4096);
    ticks_todo.push_back(13'sd4);
    drain();

    // extreme gains and setpoint, widest rate
    apply_setting(16'h8000, 16'h7fff, 16'h8000, 24'h800000, 10'h3ff);
    ticks_todo.push_back(13'sd4095);
    ticks_todo.push_back(-13'sd4096);
    ticks_todo.push_back(13'sd0);
    drain();

    // zero sample rate reads as zero speed
    apply_setting(16'h7fff, 16'h8000, 16'h7fff, 24'h7fffff, 10'd0);
    ticks_todo.push_back(13'sd4095);
    ticks_todo.push_back(-13'sd4096);
    ticks_todo.push_back(13'sd1);
    drain();

    // stop with a live drive, then restart from the kept drive
    apply_setting(16'h0040, 16'h0004, 16'h0010, 24'd0, 10'd512);
    ticks_todo.push_back(13'sd100);
    ticks_todo.push_back(-13'sd100);
    drain();
    apply_setting(16'h0040, 16'h0004, 16'h0010, -24'sd2000, 10'd512);
    ticks_todo.push_back(-13'sd4);
    ticks_todo.push_back(-13'sd3);
    drain();

    while (planned < RANDOM_ITEMS) begin
      apply_setting(rand_gain(), rand_gain(), rand_gain(), rand_target(), rand_rate());
      n = $urandom_range(60, 140);
      for (int k = 0; k < n; k++) ticks_todo.push_back(rand_count());
      planned += n;
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // driver: offers the next encoder word, holds it until taken
  always @(posedge clk) begin : drive_ticks
    duty_word_t want;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        want = pid_step(in_encoder_count);
        duty_due.push_back(want);
        ticks_sent <= ticks_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (ticks_todo.size() != 0 &&
            ((ticks_sent >= CALM_LO && ticks_sent < CALM_HI) ||
             $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_valid         <= 1'b1;
          in_encoder_count <= ticks_todo.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-offs so the block backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (ticks_sent >= next_hold_at) begin
      hold_left    <= HOLD_CYCLES;
      next_hold_at <= next_hold_at + 550;
    end
  end

  // monitor: checks each taken result word against the oldest prediction
  always @(posedge clk) begin : check_words
    duty_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (duty_due.size() == 0) begin
          log_error($sformatf("result word %0d with nothing expected", words_seen));
        end else begin
          want = duty_due.pop_front();
          if (out_fwd_duty !== want.fwd)
            log_error($sformatf("word %0d fwd_duty %0d, want %0d",
                                words_seen, out_fwd_duty, want.fwd));
          if (out_rev_duty !== want.rev)
            log_error($sformatf("word %0d rev_duty %0d, want %0d",
                                words_seen, out_rev_duty, want.rev));
          if (out_measured_speed !== want.speed)
            log_error($sformatf("word %0d measured_speed %0d, want %0d",
                                words_seen, out_measured_speed, want.speed));
        end
        words_seen <= words_seen + 1;
      end
      out_stall <= (hold_left != 0) ||
                   (!(words_seen >= CALM_LO && words_seen < CALM_HI) &&
                    $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule
